// ----- hw/rtl/owrb_pkg.sv -----
// ----------------------------------------------------------------------------
// owrb_pkg
// Shared types and constants of the overwrite-oldest ring buffer.
// ----------------------------------------------------------------------------
package owrb_pkg;

	localparam int DEPTH_DEF       = 1024;
	localparam int SAMPLE_BITS_DEF = 64;
	localparam int MAX_READ_DEF    = 64;

	localparam int CAP_W   = 11;
	localparam int LIM_W   = 7;
	localparam int FUNC_W  = 2;
	localparam int CAP_RESET = 1024;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// controller -> datapath
	typedef struct packed {
		logic push;     // write sample at head, advance
		logic clear;    // reset ring pointers, load capacity
		logic single;   // load the one-result answer of this item
		logic rd_start; // latch read limit, clear drain count
		logic rd_addr;  // read store at tail
		logic rd_take;  // load drained sample, advance tail
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take an item this cycle
		logic rd_nothing; // incoming read drains nothing
		logic rd_final;   // sample being taken is the last of the read
	} stat_t;

endpackage

// ----- hw/rtl/owrb_if.sv -----
// ----------------------------------------------------------------------------
// owrb_if
// Valid/ready channels of the ring buffer: request and result.
// ----------------------------------------------------------------------------
interface owrb_in_if #(
	parameter int SAMPLE_BITS = 64
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             func;
	logic [SAMPLE_BITS-1:0] sample_in;
	logic [6:0]             read_limit;

	modport source (output valid, output func, output sample_in, output read_limit,
		input ready);
	modport sink (input valid, input func, input sample_in, input read_limit,
		output ready);
endinterface

interface owrb_out_if #(
	parameter int SAMPLE_BITS = 64
);
	logic                   valid;
	logic                   ready;
	logic                   status;
	logic                   has_sample;
	logic [SAMPLE_BITS-1:0] sample_out;
	logic [6:0]             read_count;
	logic                   last;

	modport source (output valid, output status, output has_sample, output sample_out,
		output read_count, output last, input ready);
	modport sink (input valid, input status, input has_sample, input sample_out,
		input read_count, input last, output ready);
endinterface

// ----- hw/rtl/owrb_ram.sv -----
// ----------------------------------------------------------------------------
// owrb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module owrb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/owrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// owrb_ctrl
// Sequencer: takes items, steps a read through the store one sample at a time.
// ----------------------------------------------------------------------------
module owrb_ctrl
	import owrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  in_func,
	output logic        in_ready,
	input  stat_t       stat,
	output cmd_t        cmd
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_RD_ADDR = 3'b010,
		ST_RD_DATA = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					cmd.push  = (in_func == FUNC_PUSH);
					cmd.clear = (in_func == FUNC_CLEAR);
					if (in_func == FUNC_READ && !stat.rd_nothing) begin
						cmd.rd_start = 1'b1;
						state_nxt    = ST_RD_ADDR;
					end else begin
						cmd.single = 1'b1;
					end
				end
			end
			ST_RD_ADDR: begin
				cmd.rd_addr = 1'b1;
				state_nxt   = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (stat.out_free) begin
					cmd.rd_take = 1'b1;
					state_nxt   = stat.rd_final ? ST_IDLE : ST_RD_ADDR;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- hw/rtl/owrb_datapath.sv -----
// ----------------------------------------------------------------------------
// owrb_datapath
// Ring pointers, fill count, sample store and the output register.
// ----------------------------------------------------------------------------
module owrb_datapath
	import owrb_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_READ    = MAX_READ_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  logic [LIM_W-1:0]       read_limit,
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_wdata,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   status,
	output logic                   has_sample,
	output logic [SAMPLE_BITS-1:0] sample_out,
	output logic [LIM_W-1:0]       read_count,
	output logic                   last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CAP_W-1:0]       cap_reg_q;
	logic [CNT_W-1:0]       cap_q;
	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       tail_q;
	logic [CNT_W-1:0]       fill_q;
	logic [LIM_W-1:0]       lim_q;
	logic [LIM_W-1:0]       cnt_q;
	logic                   out_valid_q;

	logic [CNT_W-1:0]       cap_eff;
	logic [CNT_W-1:0]       head_inc;
	logic [CNT_W-1:0]       tail_inc;
	logic [IDX_W-1:0]       head_nxt;
	logic [IDX_W-1:0]       tail_nxt;
	logic                   full;
	logic [LIM_W-1:0]       lim_sat;
	logic [LIM_W-1:0]       cnt_inc;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic                   out_load;

	always_comb begin
		if (cap_reg_q == '0 || 32'(cap_reg_q) > DEPTH) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_reg_q);
		end
		head_inc = CNT_W'(head_q) + CNT_W'(1);
		tail_inc = CNT_W'(tail_q) + CNT_W'(1);
		head_nxt = (head_inc >= cap_q) ? '0 : IDX_W'(head_inc);
		tail_nxt = (tail_inc >= cap_q) ? '0 : IDX_W'(tail_inc);
		full     = (fill_q >= cap_q);
		lim_sat  = (read_limit > LIM_W'(MAX_READ)) ? LIM_W'(MAX_READ) : read_limit;
		cnt_inc  = cnt_q + LIM_W'(1);
	end

	assign out_load        = cmd.single || cmd.rd_take;
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.rd_nothing = (lim_sat == '0) || (fill_q == '0);
	assign stat.rd_final   = (cnt_inc == lim_q) || (fill_q == CNT_W'(1));
	assign out_valid       = out_valid_q;

	owrb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (head_q),
		.wdata (sample_in),
		.re    (cmd.rd_addr),
		.raddr (tail_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg_q   <= CAP_W'(CAP_RESET);
			cap_q       <= (DEPTH < CAP_RESET) ? CNT_W'(DEPTH) : CNT_W'(CAP_RESET);
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			lim_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_reg_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				head_q <= '0;
				tail_q <= '0;
				fill_q <= '0;
				cap_q  <= cap_eff;
			end
			if (cmd.push) begin
				head_q <= head_nxt;
				if (full) begin
					tail_q <= tail_nxt;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.rd_start) begin
				lim_q <= lim_sat;
				cnt_q <= '0;
			end
			if (cmd.rd_take) begin
				tail_q <= tail_nxt;
				fill_q <= fill_q - CNT_W'(1);
				cnt_q  <= cnt_inc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.single) begin
			status     <= cmd.push && full;
			has_sample <= 1'b0;
			sample_out <= '0;
			read_count <= '0;
			last       <= 1'b1;
		end else if (cmd.rd_take) begin
			status     <= 1'b0;
			has_sample <= 1'b1;
			sample_out <= rd_data;
			read_count <= cnt_inc;
			last       <= stat.rd_final;
		end
	end

endmodule

// ----- hw/rtl/overwrite_oldest_ring_buffer_top.sv -----
// ----------------------------------------------------------------------------
// overwrite_oldest_ring_buffer_top
// Sample FIFO over a ring of configurable capacity; the oldest sample is
// dropped when a push finds the ring full.
//
// Channels: in_ch takes items (func, sample_in, read_limit), out_ch returns
// results; both move an item when valid and ready are high at a clock edge.
// cfg_we / cfg_wdata load the capacity register; it takes effect at the next
// buffer-reset item (zero or above DEPTH selects DEPTH).
// Push, buffer reset, unused code and empty read: one result, registered
// in the cycle after the item is taken; a new item may follow each cycle.
// Read: one result per drained sample, each stepped through an address state
// and then a data state for the registered read of the sample store; in_ch
// stays not ready until the last sample has been handed on.
// A stalled out_ch holds its result and holds off both the sequencer and
// in_ch; nothing is lost or repeated.
// arst_n clears head, tail, fill count and the output valid, and sets the
// capacity to 1024 (clamped to DEPTH). The store itself is not cleared.
// ----------------------------------------------------------------------------
module overwrite_oldest_ring_buffer_top
	import owrb_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_READ    = MAX_READ_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	owrb_in_if.sink          in_ch,
	owrb_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	owrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_func  (in_ch.func),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	owrb_datapath #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_READ    (MAX_READ)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample_in  (in_ch.sample_in),
		.read_limit (in_ch.read_limit),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.status     (out_ch.status),
		.has_sample (out_ch.has_sample),
		.sample_out (out_ch.sample_out),
		.read_count (out_ch.read_count),
		.last       (out_ch.last)
	);

endmodule

// ----- tb/overwrite_oldest_ring_buffer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_oldest_ring_buffer_checker
// Watches the request, result and capacity ports of the ring buffer. It keeps
// its own copy of the ring and compares every result item with the oldest
// expected one. It hands the failure count and the number of outstanding
// results to the test top.
// ----------------------------------------------------------------------------
module overwrite_oldest_ring_buffer_checker
	import owrb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	owrb_in_if               in_ch,
	owrb_out_if              out_ch,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic                       status;
		logic                       has_sample;
		logic [SAMPLE_BITS_DEF-1:0] sample;
		logic [LIM_W-1:0]           count;
		logic                       last;
	} ring_result_t;

	logic [SAMPLE_BITS_DEF-1:0] sample_store [DEPTH_DEF];
	int unsigned  head_idx;
	int unsigned  tail_idx;
	int unsigned  fill;
	int unsigned  cap_reg;
	int unsigned  cap_active;
	int           errors = 0;
	ring_result_t ring_results [$];

	function automatic int unsigned clamp_cap(input int unsigned v);
		return (v == 0 || v > DEPTH_DEF) ? DEPTH_DEF : v;
	endfunction

	function automatic int unsigned ring_next(input int unsigned i);
		return (i + 1 >= cap_active) ? 0 : i + 1;
	endfunction

	function automatic void ring_update(input func_t op,
		input logic [SAMPLE_BITS_DEF-1:0] smp, input logic [LIM_W-1:0] lim);
		ring_result_t r;
		int unsigned  want;
		int unsigned  n;
		r = '0;
		r.last = 1'b1;
		case (op)
			FUNC_PUSH: begin
				sample_store[head_idx] = smp;
				head_idx = ring_next(head_idx);
				if (fill < cap_active) begin
					fill++;
				end else begin
					tail_idx = ring_next(tail_idx);
					r.status = 1'b1;
				end
				ring_results.push_back(r);
			end
			FUNC_READ: begin
				want = (lim > MAX_READ_DEF) ? MAX_READ_DEF : 32'(lim);
				n = 0;
				while (n < want && fill > 0) begin
					r = '0;
					r.has_sample = 1'b1;
					r.sample = sample_store[tail_idx];
					tail_idx = ring_next(tail_idx);
					fill--;
					n++;
					r.count = n[LIM_W-1:0];
					r.last = (n == want || fill == 0);
					ring_results.push_back(r);
				end
				if (n == 0) begin
					r = '0;
					r.last = 1'b1;
					ring_results.push_back(r);
				end
			end
			FUNC_CLEAR: begin
				head_idx = 0;
				tail_idx = 0;
				fill = 0;
				cap_active = clamp_cap(cap_reg);
				ring_results.push_back(r);
			end
			default: begin
				ring_results.push_back(r);
			end
		endcase
	endfunction

	function automatic void note_failure(input string what, input ring_result_t e,
		input ring_result_t a);
		errors++;
		if (errors <= 10)
			$display("%t %s: exp st=%0d has=%0d smp=%h cnt=%0d last=%0d, ",
				$realtime, what, e.status, e.has_sample, e.sample, e.count, e.last,
				"got st=%0d has=%0d smp=%h cnt=%0d last=%0d",
				a.status, a.has_sample, a.sample, a.count, a.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_result_t act;
		ring_result_t exp;
		if (!arst_n) begin
			head_idx = 0;
			tail_idx = 0;
			fill = 0;
			cap_reg = CAP_RESET;
			cap_active = clamp_cap(CAP_RESET);
			ring_results.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (cfg_we)
				cap_reg = 32'(cfg_wdata);
			if (out_ch.valid && out_ch.ready) begin
				act = '{out_ch.status, out_ch.has_sample, out_ch.sample_out,
					out_ch.read_count, out_ch.last};
				if (ring_results.size() == 0) begin
					note_failure("unexpected item", '0, act);
				end else begin
					exp = ring_results.pop_front();
					if (act !== exp)
						note_failure("mismatch", exp, act);
				end
			end
			if (in_ch.valid && in_ch.ready)
				ring_update(func_t'(in_ch.func), in_ch.sample_in, in_ch.read_limit);
			pending <= ring_results.size();
			fail_count <= errors;
		end
	end

endmodule

// ----- tb/overwrite_oldest_ring_buffer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_oldest_ring_buffer_top_test
// Drives the ring buffer through a directed run of pushes, reads, buffer
// resets and the unused code, then through random items under a series of
// capacities, with bursty requests and a stalling result side. The checker
// beside the block does the comparing; this top gives the verdict.
// ----------------------------------------------------------------------------
module overwrite_oldest_ring_buffer_top_test;
	import owrb_pkg::*;

	localparam int RUN_LIMIT_NS = 4_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 55;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               burst_left;
	bit               hold_req;

	owrb_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
	owrb_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) out_ch ();

	overwrite_oldest_ring_buffer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	overwrite_oldest_ring_buffer_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	task automatic send_item(input func_t op, input logic [SAMPLE_BITS_DEF-1:0] smp,
		input logic [LIM_W-1:0] lim);
		int gap;
		if (burst_left == 0) begin
			if (in_ch.valid)
				in_ch.valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
		in_ch.valid      <= 1'b1;
		in_ch.func       <= op;
		in_ch.sample_in  <= smp;
		in_ch.read_limit <= lim;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// sender pauses until every result is back
	task automatic settle();
		if (in_ch.valid)
			in_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_random();
		int                         pick;
		func_t                      op;
		logic [LIM_W-1:0]           lim;
		logic [SAMPLE_BITS_DEF-1:0] smp;
		pick = $urandom_range(0, 99);
		op = (pick < 55) ? FUNC_PUSH : (pick < 88) ? FUNC_READ
			: (pick < 94) ? FUNC_CLEAR : FUNC_NONE;
		smp = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 8)
			lim = '0;
		else if (pick < 70)
			lim = LIM_W'($urandom_range(1, 8));
		else if (pick < 85)
			lim = LIM_W'($urandom_range(9, 63));
		else if (pick < 93)
			lim = LIM_W'(MAX_READ_DEF);
		else
			lim = LIM_W'($urandom_range(MAX_READ_DEF + 1, 127));
		send_item(op, smp, lim);
	endtask

	// result side: stretches of always ready, random, sparse and periodic ready, and a requested hold of not ready
	initial begin
		int mode;
		int span;
		int hold_left;
		int tick;
		out_ch.ready = 1'b0;
		hold_left = 0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (hold_req && hold_left == 0) begin
					hold_req = 1'b0;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left != 0) begin
					hold_left--;
					out_ch.ready <= 1'b0;
				end else begin
					case (mode)
						0: out_ch.ready <= 1'b1;
						1: out_ch.ready <= 1'($urandom_range(0, 1));
						2: out_ch.ready <= ($urandom_range(0, 3) == 0);
						default: out_ch.ready <= (tick % 3 != 0);
					endcase
				end
			end
		end
	end

	initial begin
		int cap_plan [8];
		in_ch.valid      = 1'b0;
		in_ch.func       = FUNC_PUSH;
		in_ch.sample_in  = '0;
		in_ch.read_limit = '0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		arst_n           = 1'b0;
		burst_left       = 0;
		hold_req         = 1'b0;
		cap_plan = '{1, 2, 2047, 5, 0, 16, 1025, 1024};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset capacity 1024
		send_item(FUNC_READ, '0, 7'd3);
		send_item(FUNC_PUSH, '1, '0);
		send_item(FUNC_PUSH, '0, '1);
		send_item(FUNC_PUSH, 64'hA5A5_5A5A_F00F_0FF0, 7'd64);
		send_item(FUNC_READ, '1, 7'd0);
		send_item(FUNC_READ, '0, 7'd127);
		send_item(FUNC_NONE, {$urandom, $urandom}, LIM_W'($urandom_range(0, 127)));
		send_item(FUNC_PUSH, 64'h8000_0000_0000_0001, '0);
		// new capacity waits for a buffer reset
		write_capacity(11'd1);
		send_item(FUNC_PUSH, 64'h0123_4567_89AB_CDEF, '0);
		send_item(FUNC_READ, '0, 7'd64);
		send_item(FUNC_CLEAR, '1, '1);
		send_item(FUNC_PUSH, 64'h1111_2222_3333_4444, '0);
		send_item(FUNC_PUSH, 64'h5555_6666_7777_8888, '0);
		send_item(FUNC_PUSH, 64'h9999_AAAA_BBBB_CCCC, '0);
		send_item(FUNC_READ, '0, 7'd65);
		send_item(FUNC_READ, '0, 7'd1);
		send_item(FUNC_NONE, '1, '1);
		send_item(FUNC_CLEAR, '0, '0);

		foreach (cap_plan[p]) begin
			write_capacity(CAP_W'(cap_plan[p]));
			send_item(FUNC_CLEAR, '0, '0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (cap_plan[p] == 16 && i == 10)
					hold_req = 1'b1;
				send_random();
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
